// File: sv/psdq_pkg.sv
// package for the parity selective dequeue queue
// holds widths, command and status codes, and the cell control struct
// no dependencies
package psdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam logic [CMD_W-1:0] CMD_ENQ      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ_EVEN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQ_ODD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic               deq;
        logic               enq;
        logic               want;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

// File: sv/parity_selective_dequeue_queue.sv
// top level of the parity selective dequeue queue
// input register, row of psdq_cell slots, entry count and result register
// depends on psdq_pkg and psdq_cell
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  input   | in_valid / in_ready  | command, value
//  output  | out_valid / out_ready| removed_value, status, occupancy
//
// each beat goes into the input register, then through the
// cell row match chain and into the result register
// the next input beat is taken in the cycle the held one executes
// a stalled result holds the held input beat, which holds in_ready low
// reset clears the entry count and valid flags; slot values need no reset
module parity_selective_dequeue_queue
    import psdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  removed_value,
    output logic [STATUS_W-1:0]        status,
    output logic [OCC_W-1:0]           occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                pend_reg;
    logic                pend_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  removed_reg;
    logic [VALUE_W-1:0]  removed_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [OCC_W-1:0]    occ_reg;

    logic                exec;
    logic                accept;
    logic                is_enq;
    logic                is_deq;
    logic                empty;
    logic                full;
    logic                found;
    cell_ctl_t           ctl;
    logic [VALUE_W-1:0]  removed_sel;

    logic [DEPTH:0]      found_chain;
    logic [DEPTH-1:0]    take_vec;
    logic [VALUE_W-1:0]  cell_value [DEPTH];
    logic [VALUE_W-1:0]  grab [DEPTH];

    assign exec     = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg || exec;
    assign accept   = in_valid && in_ready;

    assign is_enq = (cmd_reg == CMD_ENQ);
    assign is_deq = (cmd_reg == CMD_DEQ_EVEN) || (cmd_reg == CMD_DEQ_ODD);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(DEPTH));
    assign found  = found_chain[DEPTH];

    always_comb
    begin
        ctl.deq   = exec && is_deq;
        ctl.enq   = exec && is_enq && !full;
        ctl.want  = (cmd_reg == CMD_DEQ_ODD);
        ctl.value = val_reg;
    end

    assign found_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] younger;
            if (gi == DEPTH - 1)
            begin : g_last
                assign younger = '0;
            end
            else
            begin : g_mid
                assign younger = cell_value[gi + 1];
            end

            psdq_cell u_cell (
                .clk           (clk),
                .ctl           (ctl),
                .occ           (count_reg > CW'(gi)),
                .load          (count_reg == CW'(gi)),
                .found_in      (found_chain[gi]),
                .younger_value (younger),
                .found_out     (found_chain[gi + 1]),
                .take          (take_vec[gi]),
                .cell_value    (cell_value[gi]),
                .grab          (grab[gi])
            );
        end
    endgenerate

    always_comb
    begin
        removed_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            removed_sel = removed_sel | grab[i];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        removed_next = '0;
        status_next  = ST_OK;
        case (cmd_reg)
            CMD_ENQ:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DEQ_EVEN, CMD_DEQ_ODD:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOMATCH;
                end
                else
                begin
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_sel;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign pend_next      = accept ? 1'b1 : (exec ? 1'b0 : pend_reg);
    assign out_valid_next = exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            val_reg <= value;
        end
        if (exec)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(take_vec))
        else $error("more than one slot selected for removal");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        exec && is_enq && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_deq_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        exec && is_deq && !empty && found |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not shrink the queue");

    a_found_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> !empty)
        else $error("match reported on an empty queue");

endmodule

// File: sv/psdq_cell.sv
// one queue slot of the cell row: holds a value, detects a parity match
// passes the match chain to the younger neighbor and shifts on removal
// depends on psdq_pkg
module psdq_cell
    import psdq_pkg::*;
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic               occ,
    input  logic               load,
    input  logic               found_in,
    input  logic [VALUE_W-1:0] younger_value,
    output logic               found_out,
    output logic               take,
    output logic [VALUE_W-1:0] cell_value,
    output logic [VALUE_W-1:0] grab
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               match;

    assign match      = occ && (value_reg[0] == ctl.want);
    assign found_out  = found_in || match;
    assign take       = match && !found_in;
    assign cell_value = value_reg;
    assign grab       = take ? value_reg : '0;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.deq && found_out)
        begin
            value_next = younger_value;
        end
        else if (ctl.enq && load)
        begin
            value_next = ctl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
